// File: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Types and constants shared by the tagged RPN stack evaluator and its parts.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 7;
  localparam int CNT_W   = $clog2(WORD_W);

  typedef enum logic [1:0] {
    OPC_PUSH_NUM = 2'd0,
    OPC_PUSH_OPR = 2'd1,
    OPC_EVAL     = 2'd2,
    OPC_NOP      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    AOP_ADD = 2'd0,
    AOP_SUB = 2'd1,
    AOP_MUL = 2'd2,
    AOP_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_TOP_NOT_OP  = 3'd2,
    ST_MISSING     = 3'd3,
    ST_NOT_NUMBERS = 3'd4,
    ST_DIV_ZERO    = 3'd5,
    ST_FULL        = 3'd6
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] number_value;
    alu_op_t            operator_code;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic signed [31:0]   result_value;
    logic [DEPTH_W-1:0]   stack_depth;
  } res_t;

  // One stack entry: tag set means operator
  typedef struct packed {
    logic              is_op;
    alu_op_t           opr;
    logic [WORD_W-1:0] num;
  } entry_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_RIGHT,
    S_LEFT,
    S_EXEC
  } seq_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ONE,
    A_MUL,
    A_NEG_L,
    A_NEG_R,
    A_DIV,
    A_NEG_Q
  } alu_state_t;

endpackage

// File: sv/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative arithmetic unit built round one 33-bit adder: add and subtract in
// one step, multiply by shift-and-add, signed divide by restoring steps.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::alu_req_t req,
  output rpn_pkg::alu_rsp_t rsp
);

  localparam int W = rpn_pkg::WORD_W;
  localparam int C = rpn_pkg::CNT_W;

  rpn_pkg::alu_state_t state, state_next;
  rpn_pkg::alu_op_t    op, op_next;
  logic [W-1:0]        x, x_next;
  logic [W-1:0]        y, y_next;
  logic [W-1:0]        acc, acc_next;
  logic [C-1:0]        cnt, cnt_next;
  logic                neg, neg_next;
  logic [W-1:0]        value, value_next;
  logic                done, done_next;

  logic [W-1:0] add_a, add_b;
  logic         add_sub;
  logic [W:0]   sum;

  // the one shared adder
  assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W + 1)'(add_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::A_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    op    <= op_next;
    x     <= x_next;
    y     <= y_next;
    acc   <= acc_next;
    cnt   <= cnt_next;
    neg   <= neg_next;
    value <= value_next;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    x_next     = x;
    y_next     = y;
    acc_next   = acc;
    cnt_next   = cnt;
    neg_next   = neg;
    value_next = value;
    done_next  = 1'b0;
    add_a      = x;
    add_b      = y;
    add_sub    = 1'b0;

    unique case (state)
      rpn_pkg::A_IDLE: begin
        if (req.start) begin
          op_next  = req.op;
          x_next   = req.lhs;
          y_next   = req.rhs;
          acc_next = '0;
          cnt_next = '0;
          neg_next = req.lhs[W-1] ^ req.rhs[W-1];
          unique case (req.op)
            rpn_pkg::AOP_ADD,
            rpn_pkg::AOP_SUB: state_next = rpn_pkg::A_ONE;
            rpn_pkg::AOP_MUL: state_next = rpn_pkg::A_MUL;
            rpn_pkg::AOP_DIV: state_next = rpn_pkg::A_NEG_L;
          endcase
        end
      end

      rpn_pkg::A_ONE: begin
        add_sub    = (op == rpn_pkg::AOP_SUB);
        value_next = sum[W-1:0];
        done_next  = 1'b1;
        state_next = rpn_pkg::A_IDLE;
      end

      rpn_pkg::A_MUL: begin
        add_a  = acc;
        add_b  = x;
        if (y[0]) begin
          acc_next = sum[W-1:0];
        end
        x_next   = {x[W-2:0], 1'b0};
        y_next   = {1'b0, y[W-1:1]};
        cnt_next = cnt + C'(1);
        if (cnt == C'(W - 1)) begin
          value_next = y[0] ? sum[W-1:0] : acc;
          done_next  = 1'b1;
          state_next = rpn_pkg::A_IDLE;
        end
      end

      rpn_pkg::A_NEG_L: begin
        add_a   = '0;
        add_b   = x;
        add_sub = 1'b1;
        if (x[W-1]) begin
          x_next = sum[W-1:0];
        end
        state_next = rpn_pkg::A_NEG_R;
      end

      rpn_pkg::A_NEG_R: begin
        add_a   = '0;
        add_b   = y;
        add_sub = 1'b1;
        if (y[W-1]) begin
          y_next = sum[W-1:0];
        end
        state_next = rpn_pkg::A_DIV;
      end

      rpn_pkg::A_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        add_a   = {acc[W-2:0], x[W-1]};
        add_b   = y;
        add_sub = 1'b1;
        if (sum[W]) begin
          acc_next = sum[W-1:0];
          x_next   = {x[W-2:0], 1'b1};
        end else begin
          acc_next = {acc[W-2:0], x[W-1]};
          x_next   = {x[W-2:0], 1'b0};
        end
        cnt_next = cnt + C'(1);
        if (cnt == C'(W - 1)) begin
          state_next = rpn_pkg::A_NEG_Q;
        end
      end

      rpn_pkg::A_NEG_Q: begin
        add_a      = '0;
        add_b      = x;
        add_sub    = 1'b1;
        value_next = neg ? sum[W-1:0] : x;
        done_next  = 1'b1;
        state_next = rpn_pkg::A_IDLE;
      end

      default: state_next = rpn_pkg::A_IDLE;
    endcase
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// File: sv/tagged_rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// tagged_rpn_stack_evaluator
// Bounded stack of tagged entries (number or operator) with an evaluate
// command that folds operator and two numbers into one number.
// ----------------------------------------------------------------------------
//
//  channel | signals                   | accepted when
//  --------+---------------------------+-------------------------------------
//  command | start, busy, cmd          | rising edge with start high, busy low
//  result  | done, result              | rising edge ending the done cycle
//
// A push or a no-op item is handled in the idle state; its result shows on the
// next cycle, with busy staying low so another item may follow at once.
// An evaluate item reads the top, right and left entries in turn through
// the single read port of the entry RAM, then runs the shared adder: add
// or subtract directly, multiply by shift-and-add, divide by two sign
// steps, 32 quotient bits and one sign fix; then it writes back the value.
// Failed checks end the item early, in the idle state or the top or left read state.
// Reset clears the stack pointer and the sequencer; the entry RAM is not
// cleared. Results are shown for one cycle and cannot be held off.
//
module tagged_rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rpn_pkg::cmd_t cmd,
  output logic          done,
  output rpn_pkg::res_t result
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int W      = rpn_pkg::WORD_W;

  rpn_pkg::seq_state_t state, state_next;
  logic [PTR_W-1:0]    sp, sp_next;
  rpn_pkg::alu_op_t    op, op_next;
  rpn_pkg::entry_t     rhs, rhs_next;
  rpn_pkg::res_t       res, res_next;
  logic                done_q, done_next;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  rpn_pkg::entry_t     wdata, rdata;
  rpn_pkg::alu_req_t   alu_req;
  rpn_pkg::alu_rsp_t   alu_rsp;

  logic [PTR_W-1:0]    sp_m1, sp_m2, sp_m3, sp_p1;
  logic                accept;

  assign sp_m1  = sp - PTR_W'(1);
  assign sp_m2  = sp - PTR_W'(2);
  assign sp_m3  = sp - PTR_W'(3);
  assign sp_p1  = sp + PTR_W'(1);
  assign busy   = (state != rpn_pkg::S_IDLE);
  assign accept = start && !busy;

  rpn_ram #(
    .WIDTH ($bits(rpn_pkg::entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rpn_pkg::S_IDLE;
      sp     <= '0;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      done_q <= done_next;
    end
    op  <= op_next;
    rhs <= rhs_next;
    res <= res_next;
  end

  // Read address walks down from the top: top, then right, then left.
  always_comb begin
    unique case (state)
      rpn_pkg::S_TOP:   raddr = sp_m2[ADDR_W-1:0];
      rpn_pkg::S_RIGHT: raddr = sp_m3[ADDR_W-1:0];
      default:          raddr = sp_m1[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    sp_next    = sp;
    op_next    = op;
    rhs_next   = rhs;
    res_next   = res;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = sp[ADDR_W-1:0];
    wdata      = '0;
    alu_req.start = 1'b0;
    alu_req.op    = op;
    alu_req.lhs   = rdata.num;
    alu_req.rhs   = rhs.num;

    unique case (state)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          done_next             = 1'b1;
          res_next.status       = rpn_pkg::ST_OK;
          res_next.result_value = '0;
          res_next.stack_depth  = rpn_pkg::DEPTH_W'(sp);
          unique case (cmd.opcode)
            rpn_pkg::OPC_PUSH_NUM,
            rpn_pkg::OPC_PUSH_OPR: begin
              if (sp >= PTR_W'(STACK_DEPTH)) begin
                // drop the push, flag full
                res_next.status = rpn_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                wdata.is_op = (cmd.opcode == rpn_pkg::OPC_PUSH_OPR);
                wdata.opr = (cmd.opcode == rpn_pkg::OPC_PUSH_OPR) ?
                            cmd.operator_code : rpn_pkg::AOP_ADD;
                wdata.num = (cmd.opcode == rpn_pkg::OPC_PUSH_NUM) ?
                            cmd.number_value : '0;
                sp_next   = sp_p1;
                res_next.stack_depth = rpn_pkg::DEPTH_W'(sp_p1);
              end
            end
            rpn_pkg::OPC_EVAL: begin
              if (sp == '0) begin
                res_next.status = rpn_pkg::ST_EMPTY;
              end else begin
                // hold the result until the checks are done
                done_next  = 1'b0;
                state_next = rpn_pkg::S_TOP;
              end
            end
            rpn_pkg::OPC_NOP: ;
          endcase
        end
      end

      rpn_pkg::S_TOP: begin
        // read data is the top entry
        res_next.result_value = '0;
        res_next.stack_depth  = rpn_pkg::DEPTH_W'(sp);
        if (!rdata.is_op) begin
          res_next.status = rpn_pkg::ST_TOP_NOT_OP;
          done_next       = 1'b1;
          state_next      = rpn_pkg::S_IDLE;
        end else if (sp < PTR_W'(3)) begin
          res_next.status = rpn_pkg::ST_MISSING;
          done_next       = 1'b1;
          state_next      = rpn_pkg::S_IDLE;
        end else begin
          op_next    = rdata.opr;
          state_next = rpn_pkg::S_RIGHT;
        end
      end

      rpn_pkg::S_RIGHT: begin
        rhs_next   = rdata;
        state_next = rpn_pkg::S_LEFT;
      end

      rpn_pkg::S_LEFT: begin
        // read data is the left operand
        if (rhs.is_op || rdata.is_op) begin
          res_next.status = rpn_pkg::ST_NOT_NUMBERS;
          done_next       = 1'b1;
          state_next      = rpn_pkg::S_IDLE;
        end else if (op == rpn_pkg::AOP_DIV && rhs.num == '0) begin
          res_next.status = rpn_pkg::ST_DIV_ZERO;
          done_next       = 1'b1;
          state_next      = rpn_pkg::S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_next    = rpn_pkg::S_EXEC;
        end
      end

      rpn_pkg::S_EXEC: begin
        if (alu_rsp.done) begin
          // pop three, push the value in place of the left operand
          we                    = 1'b1;
          waddr                 = sp_m3[ADDR_W-1:0];
          wdata.is_op           = 1'b0;
          wdata.opr             = rpn_pkg::AOP_ADD;
          wdata.num             = alu_rsp.value;
          sp_next               = sp_m2;
          res_next.status       = rpn_pkg::ST_OK;
          res_next.result_value = alu_rsp.value;
          res_next.stack_depth  = rpn_pkg::DEPTH_W'(sp_m2);
          done_next             = 1'b1;
          state_next            = rpn_pkg::S_IDLE;
        end
      end

      default: state_next = rpn_pkg::S_IDLE;
    endcase
  end

  assign done   = done_q;
  assign result = res;

  // width of the word is fixed by the entry layout
  if (W != 32) begin : g_bad_width
    $error("entry number field must be 32 bits");
  end

endmodule

// File: sv/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks for the tagged RPN stack evaluator, bound to the top.
// ----------------------------------------------------------------------------
module rpn_checker #(
  parameter int STACK_DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input rpn_pkg::res_t result
);

  // an accepted item either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted item neither answered nor in progress");

  // the end of a busy spell always delivers its result
  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // a failed item reports a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != rpn_pkg::ST_OK |-> result.result_value == '0)
    else $error("non-zero value on a failed item");

  // a push on a full stack leaves the depth where it was
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    done && result.status == rpn_pkg::ST_FULL |->
      result.stack_depth == rpn_pkg::DEPTH_W'(STACK_DEPTH))
    else $error("full flagged at wrong depth");

endmodule

bind tagged_rpn_stack_evaluator rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker (.*);

// File: tb/rpn_result_checker.sv
// ----------------------------------------------------------------------------
// rpn_result_checker
// Watches the command and result channels of the RPN stack evaluator. Keeps
// its own copy of the tagged stack, works out the result of every accepted
// item and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rpn_result_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  rpn_pkg::cmd_t cmd,
  input  logic          done,
  input  rpn_pkg::res_t result,
  output int            mismatches,
  output int            pending,
  output int            checked,
  output logic [6:0]    status_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  entry_t      shadow_stack [STACK_DEPTH];
  int unsigned shadow_depth;
  res_t        awaited_results [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    checked      = 0;
    status_seen  = '0;
    shadow_depth = 0;
  end

  // Print only the first few, but count every one
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Apply one item to the shadow stack and return the result it must give
  function automatic res_t apply_item(input cmd_t c);
    res_t        r;
    entry_t      top_e;
    entry_t      right_e;
    entry_t      left_e;
    logic [31:0] lv;
    logic [31:0] rv;
    logic [31:0] lmag;
    logic [31:0] rmag;
    logic [31:0] q;
    logic        div_fault;
    r.status       = ST_OK;
    r.result_value = '0;
    q              = '0;
    div_fault      = 1'b0;
    case (c.opcode)
      OPC_PUSH_NUM, OPC_PUSH_OPR: begin
        if (shadow_depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.opcode == OPC_PUSH_NUM) begin
            shadow_stack[shadow_depth] = '{1'b0, AOP_ADD, c.number_value};
          end else begin
            shadow_stack[shadow_depth] = '{1'b1, c.operator_code, 32'd0};
          end
          shadow_depth++;
        end
      end
      OPC_EVAL: begin
        if (shadow_depth == 0) begin
          r.status = ST_EMPTY;
        end else if (!shadow_stack[shadow_depth-1].is_op) begin
          r.status = ST_TOP_NOT_OP;
        end else if (shadow_depth < 3) begin
          r.status = ST_MISSING;
        end else begin
          top_e   = shadow_stack[shadow_depth-1];
          right_e = shadow_stack[shadow_depth-2];
          left_e  = shadow_stack[shadow_depth-3];
          if (right_e.is_op || left_e.is_op) begin
            r.status = ST_NOT_NUMBERS;
          end else begin
            lv = left_e.num;
            rv = right_e.num;
            case (top_e.opr)
              AOP_ADD: q = lv + rv;
              AOP_SUB: q = lv - rv;
              AOP_MUL: q = lv * rv;
              default: begin
                // divide on magnitudes, then restore the sign (truncates to zero)
                if (rv == '0) begin
                  div_fault = 1'b1;
                end else begin
                  lmag = lv[31] ? -lv : lv;
                  rmag = rv[31] ? -rv : rv;
                  q    = lmag / rmag;
                  if (lv[31] != rv[31]) q = -q;
                end
              end
            endcase
            if (div_fault) begin
              r.status = ST_DIV_ZERO;
            end else begin
              shadow_depth -= 2;
              shadow_stack[shadow_depth-1] = '{1'b0, AOP_ADD, q};
              r.result_value = q;
            end
          end
        end
      end
      default: ;
    endcase
    r.stack_depth = shadow_depth[DEPTH_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      shadow_depth = 0;
      awaited_results.delete();
    end else begin
      // retire the oldest result before taking a new item
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          want = awaited_results.pop_front();
          checked++;
          status_seen[want.status] = 1'b1;
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %s",
                                      result.status, want.status.name()));
          end
          if (result.result_value !== want.result_value) begin
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      result.result_value, want.result_value));
          end
          if (result.stack_depth !== want.stack_depth) begin
            report_mismatch($sformatf("stack_depth %0d, expected %0d",
                                      result.stack_depth, want.stack_depth));
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_item(cmd));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the tagged RPN stack evaluator with a directed opening (every status
// but full, and the arithmetic corner cases), a climb to a full stack and back, then
// random push, fold and reduce sequences with random sender gaps. Checking
// is done by a separate checker module beside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int TARGET_ITEMS = 600;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       done;
  cmd_t       cmd;
  res_t       result;

  int         mismatches;
  int         pending;
  int         checked;
  logic [6:0] status_seen;

  int         items_sent = 0;
  int         last_depth = 0;
  int         deepest    = 0;
  bit         steady     = 1'b0;

  tagged_rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  rpn_result_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) results_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .status_seen(status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout: the block stopped answering");
    $display("simulation failed");
    $finish;
  end

  // Track the depth the block last reported; it steers the random sequences
  // and lags the items still in flight by a few entries, which is harmless.
  always @(posedge clk) begin
    if (done) begin
      last_depth <= result.stack_depth;
      if (result.stack_depth > deepest) deepest <= result.stack_depth;
    end
  end

  // Mostly no gap or a short one, now and then a long one. In a steady
  // stretch the sender keeps start high from item to item.
  task automatic issue(input cmd_t c);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 45) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    // Raise (or hold) start with the new item, then wait for busy low at an edge
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  // The field that the opcode does not use carries random bits all the same
  task automatic push_number(input logic [31:0] v);
    cmd_t c;
    c.opcode        = OPC_PUSH_NUM;
    c.number_value  = v;
    c.operator_code = alu_op_t'($urandom_range(0, 3));
    issue(c);
  endtask

  task automatic push_operator(input alu_op_t op);
    cmd_t c;
    c.opcode        = OPC_PUSH_OPR;
    c.number_value  = $urandom();
    c.operator_code = op;
    issue(c);
  endtask

  task automatic evaluate();
    cmd_t c;
    c.opcode        = OPC_EVAL;
    c.number_value  = $urandom();
    c.operator_code = alu_op_t'($urandom_range(0, 3));
    issue(c);
  endtask

  // Lower start and hold off until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Extremes, zero and small values turn up often; the rest is any word
  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4, 5, 6: return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  // A zero divisor leaves junk on the stack, so let one through only rarely
  function automatic logic [31:0] right_operand(input alu_op_t op);
    logic [31:0] n;
    n = pick_number();
    if (op == AOP_DIV && n == 0 && $urandom_range(0, 19) != 0) n = 1;
    return n;
  endfunction

  initial begin
    cmd_t    c;
    alu_op_t op;
    int      d;
    int      pick;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: walk through each status code but full from an empty stack
    evaluate();                                 // empty stack
    c.opcode        = OPC_NOP;
    c.number_value  = $urandom();
    c.operator_code = alu_op_t'($urandom_range(0, 3));
    issue(c);                                   // unused opcode does nothing
    push_operator(AOP_ADD);
    evaluate();                                 // operator with nothing beneath
    push_number(32'd7);
    evaluate();                                 // number on top
    push_operator(AOP_MUL);
    evaluate();                                 // left operand is an operator
    push_operator(AOP_SUB);
    evaluate();                                 // right operand is an operator
    push_number(32'h7fff_ffff);
    push_number(32'd1);
    push_operator(AOP_ADD);
    evaluate();                                 // add wraps to most negative
    push_number(32'hffff_ffff);
    push_operator(AOP_DIV);
    evaluate();                                 // most negative over minus one
    push_number(32'd0);
    push_operator(AOP_DIV);
    evaluate();                                 // divide by zero, stack kept
    push_number(-32'sd7);
    push_number(32'd2);
    push_operator(AOP_DIV);
    evaluate();                                 // truncation toward zero

    // Climb to a full stack from a quiet block, overflow both push kinds,
    // then reduce back down with operators that cannot fault
    drain();
    d = last_depth;
    steady = ($urandom_range(0, 1) == 0);
    for (int i = d; i < STACK_DEPTH - 1; i++) push_number(pick_number());
    push_operator(alu_op_t'($urandom_range(0, 2)));
    push_number(pick_number());                 // full: dropped
    push_operator(alu_op_t'($urandom_range(0, 3)));  // full: dropped
    evaluate();
    repeat (40) begin
      steady = ($urandom_range(0, 3) == 0);
      push_operator(alu_op_t'($urandom_range(0, 2)));
      evaluate();
    end

    // Random part: mostly well-formed sequences, steered by the reported
    // depth, with a little noise
    while (items_sent < TARGET_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 4) begin
        c.opcode        = opcode_t'($urandom_range(0, 3));
        c.number_value  = pick_number();
        c.operator_code = alu_op_t'($urandom_range(0, 3));
        issue(c);
      end else if (last_depth <= 12 || (last_depth < 52 && pick >= 75)) begin
        // two fresh numbers and an operator: depth grows by one
        op = alu_op_t'($urandom_range(0, 3));
        push_number(pick_number());
        push_number(right_operand(op));
        push_operator(op);
        evaluate();
      end else if (last_depth >= 52 || pick < 40) begin
        // fold the top two numbers: depth drops by one
        push_operator(alu_op_t'($urandom_range(0, 2)));
        evaluate();
      end else begin
        // fold a fresh number into the top: depth stays put
        op = alu_op_t'($urandom_range(0, 3));
        push_number(right_operand(op));
        push_operator(op);
        evaluate();
      end
    end

    // Let the last results come home, then allow for the slowest evaluate
    drain();
    repeat (60) @(negedge clk);

    $display("%0d items driven, %0d results checked, deepest stack %0d of %0d",
             items_sent, checked, deepest, STACK_DEPTH);
    $display("status codes returned (one bit per code, ok is bit 0): %b", status_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_alu.sv
sv/tagged_rpn_stack_evaluator.sv
sv/rpn_checker.sv
tb/rpn_result_checker.sv
tb/testbench.sv
